[rtl/tpit_pkg.sv]
// Shared types and constants for the trace packet IP/TNT parser.
`timescale 1ns / 1ps

package tpit_pkg;

  // IP-compression codes carried in bits 7..5 of an IP packet header.
  localparam logic [2:0] IPC_NONE    = 3'd0;
  localparam logic [2:0] IPC_UPD16   = 3'd1;
  localparam logic [2:0] IPC_UPD32   = 3'd2;
  localparam logic [2:0] IPC_SEXT48  = 3'd3;
  localparam logic [2:0] IPC_UPD48   = 3'd4;
  localparam logic [2:0] IPC_KEEP5   = 3'd5;
  localparam logic [2:0] IPC_FULL64  = 3'd6;
  localparam logic [2:0] IPC_KEEP7   = 3'd7;

  // Header bytes.
  localparam logic [7:0] BYTE_PAD    = 8'h00;
  localparam logic [7:0] BYTE_EXT    = 8'h02;
  localparam logic [7:0] BYTE_PSB    = 8'h82;
  localparam logic [7:0] BYTE_LTNT   = 8'hA3;
  localparam logic [7:0] BYTE_ODD_NO = 8'h99;

  // Low five bits of the IP packet opcodes.
  localparam logic [4:0] OP_TIP      = 5'h0D;
  localparam logic [4:0] OP_TIP_PGE  = 5'h11;
  localparam logic [4:0] OP_TIP_PGD  = 5'h01;
  localparam logic [4:0] OP_FUP      = 5'h1D;

  localparam logic [15:0] KERNEL_TOP = 16'hFFFF;

  localparam int unsigned QDEPTH = 2;

  // Command passed from the byte parser to the executor.
  typedef struct packed {
    logic        is_tnt;
    logic [2:0]  code;
    logic [63:0] value;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] ip;
    logic [46:0] bits;
    logic [5:0]  count;
  } res_t;

endpackage

[rtl/tpit_front.sv]
// Byte parser: walks the packet grammar and emits execute commands.
`timescale 1ns / 1ps

module tpit_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [7:0]        trace_byte_i,
  input  logic              end_of_trace_i,
  output logic              cmd_valid_o,
  output tpit_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_EXT  = 3'd1;
  localparam logic [2:0] PH_PSB  = 3'd2;
  localparam logic [2:0] PH_IP   = 3'd3;
  localparam logic [2:0] PH_LTNT = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic [3:0]  left_q, left_d;
  logic [2:0]  code_q, code_d;
  logic [63:0] accum_q, accum_d;

  // Decode of the current byte as the first byte of a packet.
  logic           st_valid;
  tpit_pkg::cmd_t st_cmd;
  logic [2:0]     st_phase;
  logic [3:0]     st_left;
  logic [2:0]     st_code;
  logic [4:0]     op;
  logic           ipop;
  logic [2:0]     hdr_code;
  logic [3:0]     hdr_len;

  logic [3:0]     left_dec;
  logic [63:0]    shifted;
  logic [63:0]    ip_val;
  logic           ip_has_len;

  always_comb begin
    op       = trace_byte_i[4:0];
    ipop     = (op == tpit_pkg::OP_TIP) || (op == tpit_pkg::OP_FUP) ||
               (op == tpit_pkg::OP_TIP_PGE) || (op == tpit_pkg::OP_TIP_PGD);
    hdr_code = trace_byte_i[7:5];
    unique case (hdr_code)
      tpit_pkg::IPC_UPD16:  hdr_len = 4'd2;
      tpit_pkg::IPC_UPD32:  hdr_len = 4'd4;
      tpit_pkg::IPC_SEXT48,
      tpit_pkg::IPC_UPD48:  hdr_len = 4'd6;
      tpit_pkg::IPC_FULL64: hdr_len = 4'd8;
      default:              hdr_len = 4'd0;
    endcase

    st_valid = 1'b0;
    st_cmd   = '0;
    st_phase = PH_IDLE;
    st_left  = left_q;
    st_code  = code_q;
    if (trace_byte_i == tpit_pkg::BYTE_PAD) begin
      st_valid = 1'b0;
    end else if (trace_byte_i[0] && trace_byte_i != tpit_pkg::BYTE_ODD_NO && !ipop) begin
      st_valid        = 1'b1;
      st_cmd.is_tnt   = 1'b1;
      st_cmd.value    = {57'd0, trace_byte_i[7:1]};
    end else if (trace_byte_i == tpit_pkg::BYTE_EXT) begin
      st_phase = PH_EXT;
    end else if (ipop && hdr_code != tpit_pkg::IPC_NONE) begin
      if (hdr_len == 4'd0) begin
        // No payload follows: report the kept IP as it is.
        st_valid    = 1'b1;
        st_cmd.code = hdr_code;
      end else begin
        st_phase = PH_IP;
        st_left  = hdr_len;
        st_code  = hdr_code;
      end
    end
  end

  always_comb begin
    left_dec = (left_q != 4'd0) ? left_q - 4'd1 : 4'd0;
    shifted  = {trace_byte_i, accum_q[63:8]};
    case (code_q)
      tpit_pkg::IPC_UPD16:  ip_val = {48'd0, shifted[63:48]};
      tpit_pkg::IPC_UPD32:  ip_val = {32'd0, shifted[63:32]};
      tpit_pkg::IPC_SEXT48,
      tpit_pkg::IPC_UPD48:  ip_val = {16'd0, shifted[63:16]};
      tpit_pkg::IPC_FULL64: ip_val = shifted;
      default:              ip_val = '0;
    endcase
    ip_has_len = (code_q == tpit_pkg::IPC_UPD16) || (code_q == tpit_pkg::IPC_UPD32) ||
                 (code_q == tpit_pkg::IPC_SEXT48) || (code_q == tpit_pkg::IPC_UPD48) ||
                 (code_q == tpit_pkg::IPC_FULL64);
  end

  always_comb begin
    phase_d     = phase_q;
    left_d      = left_q;
    code_d      = code_q;
    accum_d     = accum_q;
    cmd_valid_o = 1'b0;
    cmd_o       = '0;
    if (take_i) begin
      unique case (phase_q)
        PH_EXT: begin
          if (trace_byte_i == tpit_pkg::BYTE_PSB) begin
            phase_d = PH_PSB;
            left_d  = 4'd14;
          end else if (trace_byte_i == tpit_pkg::BYTE_LTNT) begin
            phase_d = PH_LTNT;
            left_d  = 4'd6;
          end else begin
            // The lone 0x02 is dropped and this byte starts a new packet.
            phase_d     = st_phase;
            left_d      = st_left;
            code_d      = st_code;
            cmd_valid_o = st_valid;
            cmd_o       = st_cmd;
          end
        end
        PH_PSB: begin
          if (left_q <= 4'd1) begin
            phase_d = PH_IDLE;
          end
          left_d = left_dec;
        end
        PH_IP, PH_LTNT: begin
          accum_d = shifted;
          left_d  = left_dec;
          if (left_dec == 4'd0) begin
            phase_d = PH_IDLE;
            if (phase_q == PH_LTNT) begin
              cmd_valid_o  = 1'b1;
              cmd_o.is_tnt = 1'b1;
              cmd_o.value  = {16'd0, shifted[63:16]};
            end else if (ip_has_len) begin
              cmd_valid_o = 1'b1;
              cmd_o.code  = code_q;
              cmd_o.value = ip_val;
            end
          end
        end
        default: begin
          phase_d     = st_phase;
          left_d      = st_left;
          code_d      = st_code;
          cmd_valid_o = st_valid;
          cmd_o       = st_cmd;
        end
      endcase
      if (end_of_trace_i) begin
        phase_d = PH_IDLE;
        left_d  = 4'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      left_q  <= 4'd0;
      code_q  <= tpit_pkg::IPC_NONE;
    end else begin
      phase_q <= phase_d;
      left_q  <= left_d;
      code_q  <= code_d;
    end
  end

  always_ff @(posedge clk_i) begin
    accum_q <= accum_d;
  end

endmodule

[rtl/tpit_cmd_queue.sv]
// Two-entry command queue between the byte parser and the executor.
`timescale 1ns / 1ps

module tpit_cmd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tpit_pkg::cmd_t    cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output tpit_pkg::cmd_t    cmd_o
);

  tpit_pkg::cmd_t mem_q [tpit_pkg::QDEPTH];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'(tpit_pkg::QDEPTH));
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

[rtl/tpit_back.sv]
// Executor: keeps the IP, unpacks TNT groups and buffers the results.
`timescale 1ns / 1ps

module tpit_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  tpit_pkg::cmd_t    cmd_i,
  output logic              cmd_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output tpit_pkg::res_t    res_o
);

  logic [63:0]    ip_q, ip_d;
  tpit_pkg::res_t mem_q [tpit_pkg::QDEPTH];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q, cnt_d;

  logic           take;
  logic           do_pop;
  logic           res_valid;
  tpit_pkg::res_t res;
  logic [63:0]    v;
  logic [5:0]     top;
  logic [46:0]    mask;

  assign take      = cmd_valid_i && (cnt_q != 2'(tpit_pkg::QDEPTH));
  assign cmd_pop_o = take;
  assign empty_o   = (cnt_q == 2'd0);
  assign do_pop    = pop_i && !empty_o;
  assign res_o     = mem_q[rd_q];
  assign v         = cmd_i.value;

  // Highest set stop bit among bits 47..1 of the TNT payload.
  always_comb begin
    top = 6'd0;
    for (int i = 1; i < 48; i++) begin
      if (v[i]) begin
        top = 6'(i);
      end
    end
    for (int i = 0; i < 47; i++) begin
      mask[i] = (6'(i) < top);
    end
  end

  always_comb begin
    ip_d = ip_q;
    if (!cmd_i.is_tnt) begin
      case (cmd_i.code)
        tpit_pkg::IPC_UPD16:  ip_d = {ip_q[63:16], v[15:0]};
        tpit_pkg::IPC_UPD32:  ip_d = {ip_q[63:32], v[31:0]};
        tpit_pkg::IPC_SEXT48: ip_d = {{16{v[47]}}, v[47:0]};
        tpit_pkg::IPC_UPD48:  ip_d = {ip_q[63:48], v[47:0]};
        tpit_pkg::IPC_FULL64: ip_d = v;
        default:              ip_d = ip_q;
      endcase
    end

    res = '0;
    if (cmd_i.is_tnt) begin
      res_valid = (top != 6'd0);
      res.kind  = 1'b1;
      res.bits  = v[46:0] & mask;
      res.count = top;
    end else begin
      res_valid = (ip_d[63:48] == tpit_pkg::KERNEL_TOP);
      res.kind  = 1'b0;
      res.ip    = ip_d;
    end
  end

  always_comb begin
    case ({take && res_valid, do_pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ip_q  <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (take) begin
        ip_q <= ip_d;
      end
      if (take && res_valid) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && res_valid) begin
      mem_q[wr_q] <= res;
    end
  end

endmodule

[rtl/trace_packet_ip_tnt_parser.sv]
// Top level of the trace packet IP/TNT parser.
`timescale 1ns / 1ps

// Takes one trace byte per clock cycle (push/full) and delivers IP updates in
// the kernel range and TNT outcome groups through a result queue (empty/pop).
// A byte parser classifies the packets and hands at most one command per
// finished packet through a two-entry queue to an executor that owns the
// 64-bit IP and a two-entry result queue. Sustained rate is one byte per
// cycle; full rises only when the result side backs up. Each command is
// registered in the command queue before its result enters the result queue.
module trace_packet_ip_tnt_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push,
  output logic         full,
  input  logic [7:0]   trace_byte_i,
  input  logic         end_of_trace_i,
  output logic         empty,
  input  logic         pop,
  output logic         result_kind_o,
  output logic [63:0]  ip_value_o,
  output logic [46:0]  outcome_bits_o,
  output logic [5:0]   outcome_count_o
);

  logic           take;
  logic           f_valid;
  tpit_pkg::cmd_t f_cmd;
  logic           q_valid;
  tpit_pkg::cmd_t q_cmd;
  logic           q_pop;
  tpit_pkg::res_t res;

  assign take = push && !full;

  tpit_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .trace_byte_i   (trace_byte_i),
    .end_of_trace_i (end_of_trace_i),
    .cmd_valid_o    (f_valid),
    .cmd_o          (f_cmd)
  );

  tpit_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .cmd_i   (f_cmd),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  tpit_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign result_kind_o   = res.kind;
  assign ip_value_o      = res.ip;
  assign outcome_bits_o  = res.bits;
  assign outcome_count_o = res.count;

endmodule

[bench/tb_trace_packet_ip_tnt_parser.sv]
// Self-checking testbench for the trace packet IP/TNT parser.
`timescale 1ns / 1ps

module tb_trace_packet_ip_tnt_parser;
  import tpit_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXT,
    ST_PSB,
    ST_IP,
    ST_LTNT
  } parse_state_e;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } trace_item_t;

  // Decodes the accepted byte stream on its own and holds the results it predicts.
  class ip_tnt_scoreboard;
    parse_state_e phase;
    logic [3:0]   left;
    logic [63:0]  ip_reg;
    logic [2:0]   code;
    logic [63:0]  accum;
    res_t         pending_outcomes[$];
    int           errors;

    function new();
      phase  = ST_IDLE;
      left   = '0;
      ip_reg = '0;
      code   = IPC_NONE;
      accum  = '0;
      errors = 0;
    endfunction

    static function int unsigned ip_bytes(logic [2:0] c);
      case (c)
        IPC_UPD16:             return 2;
        IPC_UPD32:             return 4;
        IPC_SEXT48, IPC_UPD48: return 6;
        IPC_FULL64:            return 8;
        default:               return 0;
      endcase
    endfunction

    function void report_ip();
      res_t r;
      if (ip_reg[63:48] == KERNEL_TOP) begin
        r.kind  = 1'b0;
        r.ip    = ip_reg;
        r.bits  = '0;
        r.count = '0;
        pending_outcomes.push_back(r);
      end
    endfunction

    // Outcome bits are everything below the highest set stop bit.
    function void report_tnt(logic [63:0] p);
      res_t        r;
      int unsigned top;
      logic [63:0] m;
      top = 0;
      for (int i = 1; i < 48; i++)
        if (p[i]) top = i;
      if (top != 0) begin
        m       = (64'd1 << top) - 64'd1;
        r.kind  = 1'b1;
        r.ip    = '0;
        r.bits  = p[46:0] & m[46:0];
        r.count = 6'(top);
        pending_outcomes.push_back(r);
      end
    endfunction

    function void apply_ip(logic [2:0] c, logic [63:0] v);
      case (c)
        IPC_UPD16:  ip_reg[15:0] = v[15:0];
        IPC_UPD32:  ip_reg[31:0] = v[31:0];
        IPC_SEXT48: ip_reg = {{16{v[47]}}, v[47:0]};
        IPC_UPD48:  ip_reg[47:0] = v[47:0];
        IPC_FULL64: ip_reg = v;
        default: ;
      endcase
    endfunction

    function void start_packet(logic [7:0] b);
      logic        is_ip;
      logic [2:0]  c;
      int unsigned n;
      is_ip = (b[4:0] == OP_TIP) || (b[4:0] == OP_FUP) ||
              (b[4:0] == OP_TIP_PGE) || (b[4:0] == OP_TIP_PGD);
      c = b[7:5];
      n = ip_bytes(c);
      if (b == BYTE_PAD) begin
      end else if (b[0] && b != BYTE_ODD_NO && !is_ip) begin
        report_tnt({57'd0, b[7:1]});
      end else if (b == BYTE_EXT) begin
        phase = ST_EXT;
      end else if (is_ip && c != IPC_NONE) begin
        if (n == 0) begin
          report_ip();
        end else begin
          code  = c;
          left  = 4'(n);
          accum = '0;
          phase = ST_IP;
        end
      end
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      int unsigned len;
      case (phase)
        ST_EXT: begin
          phase = ST_IDLE;
          if (b == BYTE_PSB) begin
            phase = ST_PSB;
            left  = 4'd14;
          end else if (b == BYTE_LTNT) begin
            phase = ST_LTNT;
            left  = 4'd6;
            accum = '0;
          end else begin
            start_packet(b);
          end
        end
        ST_PSB: begin
          if (left <= 4'd1) phase = ST_IDLE;
          left = (left != 0) ? left - 4'd1 : 4'd0;
        end
        ST_IP, ST_LTNT: begin
          accum = {b, accum[63:8]};
          if (left > 0) left = left - 4'd1;
          if (left == 0) begin
            if (phase == ST_LTNT) begin
              phase = ST_IDLE;
              report_tnt(accum >> 16);
            end else begin
              len   = ip_bytes(code);
              phase = ST_IDLE;
              if (len != 0) begin
                apply_ip(code, accum >> (64 - 8 * len));
                report_ip();
              end
            end
          end
        end
        default: begin
          phase = ST_IDLE;
          start_packet(b);
        end
      endcase
      if (last) begin
        phase = ST_IDLE;
        left  = '0;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result kind %0d ip %h bits %h count %0d", $time,
                 got.kind, got.ip, got.bits, got.count);
        errors++;
        return;
      end
      want = pending_outcomes.pop_front();
      if (got.kind !== want.kind) begin
        $display("%0t: result_kind expected %0d got %0d", $time, want.kind, got.kind);
        errors++;
      end
      if (got.ip !== want.ip) begin
        $display("%0t: ip_value expected %h got %h", $time, want.ip, got.ip);
        errors++;
      end
      if (got.bits !== want.bits) begin
        $display("%0t: outcome_bits expected %h got %h", $time, want.bits, got.bits);
        errors++;
      end
      if (got.count !== want.count) begin
        $display("%0t: outcome_count expected %0d got %0d", $time, want.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        push           = 1'b0;
  logic        full;
  logic [7:0]  trace_byte_i   = 8'h00;
  logic        end_of_trace_i = 1'b0;
  logic        empty;
  logic        pop            = 1'b0;
  logic        result_kind_o;
  logic [63:0] ip_value_o;
  logic [46:0] outcome_bits_o;
  logic [5:0]  outcome_count_o;

  ip_tnt_scoreboard sb = new();
  trace_item_t      stream_q[$];
  int               bytes_sent = 0;

  trace_packet_ip_tnt_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .trace_byte_i   (trace_byte_i),
    .end_of_trace_i (end_of_trace_i),
    .empty          (empty),
    .pop            (pop),
    .result_kind_o  (result_kind_o),
    .ip_value_o     (ip_value_o),
    .outcome_bits_o (outcome_bits_o),
    .outcome_count_o(outcome_count_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic add_byte(logic [7:0] b, logic last = 1'b0);
    trace_item_t t;
    t.b    = b;
    t.last = last;
    stream_q.push_back(t);
  endtask

  function automatic logic [4:0] pick_ip_op();
    case ($urandom_range(3))
      0:       return OP_TIP;
      1:       return OP_TIP_PGE;
      2:       return OP_TIP_PGD;
      default: return OP_FUP;
    endcase
  endfunction

  task automatic add_ip_packet();
    logic [2:0]  c;
    logic [63:0] v;
    int unsigned n;
    logic        cut_last;
    c = 3'($urandom_range(7));
    v = {$urandom, $urandom};
    if ($urandom_range(99) < 60) v[63:48] = KERNEL_TOP;
    if ($urandom_range(99) < 50) v[47] = 1'b1;
    n = ip_tnt_scoreboard::ip_bytes(c);
    cut_last = ($urandom_range(99) < 5);
    add_byte({c, pick_ip_op()}, cut_last && n == 0);
    for (int i = 0; i < n; i++)
      add_byte(v[8*i +: 8], cut_last && i == n - 1);
  endtask

  task automatic add_long_tnt();
    int unsigned used;
    used = $urandom_range(6);
    add_byte(BYTE_EXT);
    add_byte(BYTE_LTNT);
    for (int i = 0; i < 6; i++)
      add_byte((i < used) ? 8'($urandom_range(255)) : 8'h00);
  endtask

  task automatic add_psb();
    add_byte(BYTE_EXT);
    add_byte(BYTE_PSB);
    for (int i = 0; i < 14; i++) add_byte(8'($urandom_range(255)));
  endtask

  // A packet whose tail is replaced by the end marker on an earlier byte.
  task automatic add_cut_packet();
    int unsigned k;
    logic [2:0]  c;
    case ($urandom_range(3))
      0: begin
        add_byte(BYTE_EXT);
        add_byte(BYTE_LTNT);
        k = $urandom_range(5);
      end
      1: begin
        add_byte(BYTE_EXT);
        add_byte(BYTE_PSB);
        k = $urandom_range(13);
      end
      2: begin
        add_byte(BYTE_EXT, 1'b1);
        k = 0;
      end
      default: begin
        c = ($urandom_range(1) != 0) ? IPC_FULL64 : 3'($urandom_range(1, 4));
        k = $urandom_range(ip_tnt_scoreboard::ip_bytes(c) - 1);
        add_byte({c, pick_ip_op()}, k == 0);
      end
    endcase
    for (int i = 0; i < k; i++) add_byte(8'($urandom_range(255)), i == k - 1);
  endtask

  task automatic build_stream();
    int unsigned r;
    add_byte(BYTE_PAD);
    add_byte(8'hFF);
    add_byte(8'h03);
    add_byte(BYTE_ODD_NO);
    // Full 64-bit kernel IP, then code five and code seven reports of it.
    add_byte({IPC_FULL64, OP_TIP});
    add_byte(8'h78); add_byte(8'h56); add_byte(8'h34); add_byte(8'h12);
    add_byte(8'h00); add_byte(8'h80); add_byte(8'hFF); add_byte(8'hFF);
    add_byte({IPC_KEEP5, OP_TIP_PGE});
    add_byte({IPC_KEEP7, OP_TIP_PGD});
    add_byte({IPC_NONE, OP_FUP});
    add_byte(BYTE_EXT);
    add_byte(BYTE_LTNT);
    for (int i = 0; i < 6; i++) add_byte(8'hFF);
    add_byte(BYTE_EXT);
    add_byte(8'h45);
    add_byte({IPC_SEXT48, OP_FUP});
    add_byte(8'h11);
    add_byte(8'h22, 1'b1);
    while (stream_q.size() < 800) begin
      r = $urandom_range(99);
      if (r < 20) add_byte({7'($urandom_range(127)), 1'b1});
      else if (r < 26) add_byte(BYTE_PAD);
      else if (r < 32) add_psb();
      else if (r < 47) add_long_tnt();
      else if (r < 80) add_ip_packet();
      else if (r < 87) begin
        add_byte(BYTE_EXT);
        add_byte(8'($urandom_range(255)));
      end else if (r < 94) add_byte(8'($urandom_range(255)), $urandom_range(99) < 10);
      else add_cut_packet();
    end
  endtask

  task automatic send_stream();
    int  idx;
    bit  accepted;
    idx = 0;
    while (idx < stream_q.size()) begin
      @(posedge clk_i);
      accepted = push && !full;
      if (accepted) begin
        sb.note_byte(trace_byte_i, end_of_trace_i);
        idx++;
        bytes_sent = idx;
      end
      if (push && !accepted) begin
        // Hold the offered byte until the parser takes it.
      end else if (idx < stream_q.size() &&
                   ((idx >= 400 && idx < 560) || $urandom_range(99) >= 24)) begin
        trace_byte_i   <= stream_q[idx].b;
        end_of_trace_i <= stream_q[idx].last;
        push           <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  endtask

  initial begin : result_side
    int   cyc;
    int   hold_left;
    bit   held;
    res_t got;
    cyc       = 0;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        got.kind  = result_kind_o;
        got.ip    = ip_value_o;
        got.bits  = outcome_bits_o;
        got.count = outcome_count_o;
        sb.check_result(got);
      end
      cyc++;
      // One long hold-off while the sender keeps going, so that full rises.
      if (!held && bytes_sent >= 650) begin
        held      = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (cyc >= 150 && cyc < 450) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(99) >= 24);
      end
    end
  end

  initial begin
    build_stream();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_stream();
    while (sb.pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

[files.f]
rtl/tpit_pkg.sv
rtl/tpit_front.sv
rtl/tpit_cmd_queue.sv
rtl/tpit_back.sv
rtl/trace_packet_ip_tnt_parser.sv
bench/tb_trace_packet_ip_tnt_parser.sv
